// ===== hw/rtl/mandelbrot_smooth_escape_count_assert.svh =====
// Assertion macros used by the smooth escape count checker
`ifndef MANDELBROT_SMOOTH_ESCAPE_COUNT_ASSERT_SVH
`define MANDELBROT_SMOOTH_ESCAPE_COUNT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define MSE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define MSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mse_pkg.sv =====
// Types and constants of the smooth escape count block
`timescale 1ns / 1ps
`default_nettype none

package mse_pkg;

    localparam int COORD_W    = 32;
    localparam int SMOOTH_W   = 29;
    localparam int CNT_W      = 12;
    localparam int RAD_W      = 9;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 12;
    localparam int Z_W        = 64;
    localparam int LEN2_FRAC  = 24;
    localparam int LOG_FRAC   = 16;
    localparam int LOG_W      = 22;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BAILOUT  = CFG_IDX_W'(1);

    localparam logic [CNT_W-1:0] MAX_ITER_RST = 12'd400;
    localparam logic [RAD_W-1:0] BAILOUT_RST  = 9'd100;
    localparam logic [RAD_W-1:0] RAD_MIN      = 9'd2;
    localparam logic [RAD_W-1:0] RAD_MAX      = 9'd256;

    typedef struct packed {
        logic signed [COORD_W-1:0] c_real;
        logic signed [COORD_W-1:0] c_imag;
    } t_req;

    typedef struct packed {
        logic signed [SMOOTH_W-1:0] smooth_count;
        logic        [CNT_W-1:0]    raw_count;
        logic                       escaped;
    } t_res;

    // One pixel job with configuration captured and the radius already clamped
    typedef struct packed {
        logic [Z_W-1:0]   c_real;
        logic [Z_W-1:0]   c_imag;
        logic [CNT_W-1:0] lim;
        logic [RAD_W-1:0] rad;
    } t_job;

    typedef struct packed {
        logic           start;
        logic [Z_W-1:0] value;
    } t_log_req;

    typedef struct packed {
        logic             done;
        logic [LOG_W-1:0] result;
    } t_log_rsp;

endpackage

`default_nettype wire

// ===== hw/rtl/mandelbrot_smooth_escape_count.sv =====
// Orbit step: update, multiply, drain, finish, compare; four log2 runs if escaped.
// Throughput: one pixel at a time in the back end; the step cost is set by the
// shared 32x32 multiplier taking 12 partial products per step.
// A two-entry job queue takes new requests while a pixel iterates.
// Reset: synchronous, active low; limit 400, radius 100, queue empty, no strobe.
// The receiver cannot stall: each result shows on o_res for one cycle with o_strobe.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_smooth_escape_count import mse_pkg::*; #(
    parameter int COORD_FRAC_BITS = 28
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_req                  i_req,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_strobe,
    output t_res                       o_res
);

    logic job_valid;
    t_job job;
    logic job_pop;

    mse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    mse_back #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .o_strobe    (o_strobe),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/mse_front.sv =====
// Front end: configuration registers, request intake and job queue
`timescale 1ns / 1ps
`default_nettype none

module mse_front import mse_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_req                  i_req,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_job_valid,
    output t_job                       o_job,
    input  wire logic                  i_job_pop
);

    logic [CNT_W-1:0] r_max_iter;
    logic [RAD_W-1:0] r_bailout;
    t_job             r_q [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_cnt;
    t_job             job_in;
    logic             push;

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_cnt == 2'd2);
    assign push        = start && !busy;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rd_ptr];

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= MAX_ITER_RST;
            r_bailout  <= BAILOUT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MAX_ITER: r_max_iter <= i_cfg_data;
                REG_BAILOUT:  r_bailout  <= i_cfg_data[RAD_W-1:0];
                default:      ;
            endcase
        end
    end

    // Clamp the radius, sign-extend the coordinate; the limit register spans the count width
    always_comb begin
        job_in.c_real = {{(Z_W-COORD_W){i_req.c_real[COORD_W-1]}}, i_req.c_real};
        job_in.c_imag = {{(Z_W-COORD_W){i_req.c_imag[COORD_W-1]}}, i_req.c_imag};
        job_in.lim    = r_max_iter;
        if (r_bailout < RAD_MIN) begin
            job_in.rad = RAD_MIN;
        end else if (r_bailout > RAD_MAX) begin
            job_in.rad = RAD_MAX;
        end else begin
            job_in.rad = r_bailout;
        end
    end

    // Store accepted requests
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= job_in;
        end
    end

    // Advance queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_job_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({push, i_job_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mse_log2.sv =====
// Sequential log2 unit: leading-one search, then 16 squaring steps
`timescale 1ns / 1ps
`default_nettype none

module mse_log2 import mse_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_log_req i_req,
    output t_log_rsp      o_rsp
);

    typedef enum logic [1:0] {
        L_IDLE,
        L_NORM,
        L_SQ
    } t_lstate;

    t_lstate        r_state;
    logic [Z_W-1:0] r_w;
    logic [5:0]     r_e;
    logic [30:0]    r_m;
    logic [15:0]    r_frac;
    logic [3:0]     r_i;
    logic           r_done;
    logic [LOG_W-1:0] r_result;
    logic [61:0]    sq;
    logic [31:0]    t;
    logic [15:0]    frac_next;

    assign sq        = 62'(r_m) * 62'(r_m);
    assign t         = sq[61:30];
    assign frac_next = {r_frac[14:0], t[31]};
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_result;

    // Normalize, then square the mantissa once per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                L_IDLE: begin
                    if (i_req.start) begin
                        if (i_req.value == '0) begin
                            r_result <= '0;
                            r_done   <= 1'b1;
                        end else begin
                            r_w     <= i_req.value;
                            r_e     <= 6'd63;
                            r_state <= L_NORM;
                        end
                    end
                end
                L_NORM: begin
                    if (r_w[Z_W-1]) begin
                        r_m     <= r_w[Z_W-1:Z_W-31];
                        r_frac  <= '0;
                        r_i     <= '0;
                        r_state <= L_SQ;
                    end else if (r_w[Z_W-1:Z_W-8] == 8'd0) begin
                        r_w <= r_w << 8;
                        r_e <= r_e - 6'd8;
                    end else begin
                        r_w <= r_w << 1;
                        r_e <= r_e - 6'd1;
                    end
                end
                L_SQ: begin
                    r_frac <= frac_next;
                    r_m    <= t[31] ? t[31:1] : t[30:0];
                    r_i    <= r_i + 4'd1;
                    if (r_i == 4'd15) begin
                        r_result <= {r_e, frac_next};
                        r_done   <= 1'b1;
                        r_state  <= L_IDLE;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mse_back.sv =====
// Back end: orbit iteration over a shared 32x32 multiplier and smoothing
`timescale 1ns / 1ps
`default_nettype none

module mse_back import mse_pkg::*; #(
    parameter int COORD_FRAC_BITS = 28
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    input  wire t_job i_job,
    output logic      o_job_pop,
    output logic      o_strobe,
    output t_res      o_res
);

    localparam int SH_SQ  = COORD_FRAC_BITS;
    localparam int SH_XY  = COORD_FRAC_BITS - 1;
    localparam int SH_LEN = 2 * COORD_FRAC_BITS - LEN2_FRAC;
    localparam logic [Z_W-1:0] LEN2_OFS = Z_W'(LEN2_FRAC) << LOG_FRAC;
    localparam logic [LOG_W-1:0] ONE_OFS = LOG_W'(LOG_FRAC) << LOG_FRAC;
    localparam logic signed [33:0] LO_LIM  = -34'sd65536;
    localparam logic signed [33:0] HI_LIM  = 34'((64'd1 << (CNT_W + 16)) - 64'd1);
    localparam logic signed [33:0] ONE_Q16 = 34'sd65536;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD,
        S_MUL,
        S_DRAIN,
        S_FIN,
        S_CMP,
        S_LOG_A,
        S_LOG_B,
        S_LOG_R,
        S_LOG_C,
        S_SMOOTH
    } t_state;

    t_state            r_state;
    logic [Z_W-1:0]    r_cr;
    logic [Z_W-1:0]    r_ci;
    logic [CNT_W-1:0]  r_lim;
    logic [RAD_W-1:0]  r_rad;
    logic [Z_W-1:0]    r_thr;
    logic [Z_W-1:0]    r_x;
    logic [Z_W-1:0]    r_y;
    logic [Z_W-1:0]    r_xx;
    logic [Z_W-1:0]    r_yy;
    logic [Z_W-1:0]    r_xy;
    logic [Z_W-1:0]    r_len2;
    logic [CNT_W-1:0]  r_n;
    logic              r_esc;
    logic [1:0]        r_prod;
    logic [1:0]        r_part;
    logic [63:0]       r_pp;
    logic              r_pp_vld;
    logic [1:0]        r_pp_prod;
    logic [1:0]        r_pp_sh;
    logic [127:0]      r_acc [3];
    logic [LOG_W-1:0]  r_b;
    logic              r_log_start;
    logic [Z_W-1:0]    r_log_value;
    logic              r_strobe;
    t_res              r_res;
    t_log_req          log_req;
    t_log_rsp          log_rsp;
    logic [Z_W-1:0]    mag_x;
    logic [Z_W-1:0]    mag_y;
    logic [Z_W-1:0]    op_a;
    logic [Z_W-1:0]    op_b;
    logic [31:0]       half_a;
    logic [31:0]       half_b;
    logic [Z_W-1:0]    xy_mag;
    logic [17:0]       rad_sq;
    logic signed [33:0] smooth_raw;
    logic signed [33:0] smooth_sat;

    assign log_req.start = r_log_start;
    assign log_req.value = r_log_value;

    mse_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (log_req),
        .o_rsp   (log_rsp)
    );

    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;
    assign o_strobe  = r_strobe;
    assign o_res     = r_res;

    // Select operand halves for the current partial product
    always_comb begin
        mag_x = r_x[Z_W-1] ? (Z_W'(0) - r_x) : r_x;
        mag_y = r_y[Z_W-1] ? (Z_W'(0) - r_y) : r_y;
        case (r_prod)
            2'd0:    begin op_a = mag_x; op_b = mag_x; end
            2'd1:    begin op_a = mag_y; op_b = mag_y; end
            default: begin op_a = mag_x; op_b = mag_y; end
        endcase
        half_a = r_part[1] ? op_a[63:32] : op_a[31:0];
        half_b = r_part[0] ? op_b[63:32] : op_b[31:0];
    end

    assign xy_mag = Z_W'(r_acc[2] >> SH_XY);
    assign rad_sq = 18'(i_job.rad) * 18'(i_job.rad);

    // Form smoothed count and saturate; drop the Q.16 offset of log2 log2 R
    always_comb begin
        if (r_esc) begin
            smooth_raw = $signed({6'd0, r_n, 16'd0}) - $signed({12'd0, r_b})
                       + $signed({12'd0, log_rsp.result}) - $signed({12'd0, ONE_OFS})
                       + ONE_Q16;
        end else begin
            smooth_raw = $signed({6'd0, r_n, 16'd0});
        end
        if (smooth_raw < LO_LIM) begin
            smooth_sat = LO_LIM;
        end else if (smooth_raw > HI_LIM) begin
            smooth_sat = HI_LIM;
        end else begin
            smooth_sat = smooth_raw;
        end
    end

    // Accumulate partial products into the three full-width products
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD) begin
            r_acc[0] <= '0;
            r_acc[1] <= '0;
            r_acc[2] <= '0;
        end else if (r_pp_vld) begin
            r_acc[r_pp_prod] <= r_acc[r_pp_prod] + ({64'd0, r_pp} << {r_pp_sh, 5'd0});
        end
    end

    // Sequence the orbit, the log steps and the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pp_vld    <= 1'b0;
            r_log_start <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_pp_vld    <= 1'b0;
            r_log_start <= 1'b0;
            r_strobe    <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_cr    <= i_job.c_real;
                        r_ci    <= i_job.c_imag;
                        r_lim   <= i_job.lim;
                        r_rad   <= i_job.rad;
                        r_thr   <= Z_W'(rad_sq) << LEN2_FRAC;
                        r_xx    <= '0;
                        r_yy    <= '0;
                        r_xy    <= '0;
                        r_n     <= '0;
                        r_esc   <= 1'b0;
                        r_state <= (i_job.lim == '0) ? S_SMOOTH : S_UPD;
                    end
                end
                S_UPD: begin
                    r_x     <= r_xx - r_yy + r_cr;
                    r_y     <= r_xy + r_ci;
                    r_prod  <= 2'd0;
                    r_part  <= 2'd0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_pp      <= 64'(half_a) * 64'(half_b);
                    r_pp_vld  <= 1'b1;
                    r_pp_prod <= r_prod;
                    r_pp_sh   <= 2'(r_part[1]) + 2'(r_part[0]);
                    r_part    <= r_part + 2'd1;
                    if (r_part == 2'd3) begin
                        r_prod <= r_prod + 2'd1;
                        if (r_prod == 2'd2) begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_xx    <= Z_W'(r_acc[0] >> SH_SQ);
                    r_yy    <= Z_W'(r_acc[1] >> SH_SQ);
                    r_xy    <= (r_x[Z_W-1] ^ r_y[Z_W-1]) ? (Z_W'(0) - xy_mag) : xy_mag;
                    r_len2  <= Z_W'(r_acc[0] >> SH_LEN) + Z_W'(r_acc[1] >> SH_LEN);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_len2 > r_thr) begin
                        r_esc       <= 1'b1;
                        r_log_start <= 1'b1;
                        r_log_value <= r_len2;
                        r_state     <= S_LOG_A;
                    end else begin
                        r_n     <= r_n + 12'd1;
                        r_state <= ((r_n + 12'd1) == r_lim) ? S_SMOOTH : S_UPD;
                    end
                end
                S_LOG_A: begin
                    if (log_rsp.done) begin
                        r_log_start <= 1'b1;
                        r_log_value <= Z_W'(log_rsp.result) - LEN2_OFS;
                        r_state     <= S_LOG_B;
                    end
                end
                S_LOG_B: begin
                    if (log_rsp.done) begin
                        r_b         <= log_rsp.result - ONE_OFS;
                        r_log_start <= 1'b1;
                        r_log_value <= Z_W'(r_rad);
                        r_state     <= S_LOG_R;
                    end
                end
                S_LOG_R: begin
                    if (log_rsp.done) begin
                        r_log_start <= 1'b1;
                        r_log_value <= Z_W'(log_rsp.result);
                        r_state     <= S_LOG_C;
                    end
                end
                S_LOG_C: begin
                    if (log_rsp.done) begin
                        r_state <= S_SMOOTH;
                    end
                end
                S_SMOOTH: begin
                    // In the escaped case log_rsp.result still holds log2 log2 R
                    r_res.smooth_count <= smooth_sat[SMOOTH_W-1:0];
                    r_res.raw_count    <= r_n;
                    r_res.escaped      <= r_esc;
                    r_strobe           <= 1'b1;
                    r_state            <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mse_checker.sv =====
// Port-level checker for the smooth escape count block and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "mandelbrot_smooth_escape_count_assert.svh"

module mse_checker import mse_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_strobe,
    input wire t_res o_res
);

    // Inside pixels carry the plain count
    `MSE_ASSERT_IMPL(a_inside_plain, i_clk, i_rst_n, o_strobe && !o_res.escaped, o_res.smooth_count == $signed({1'b0, o_res.raw_count, 16'd0}), "inside result not count")

    // Results never come in adjacent cycles
    `MSE_ASSERT_NEXT(a_strobe_gap, i_clk, i_rst_n, o_strobe, !o_strobe, "back-to-back results")

    // Smoothed count stays at or above the lower saturation bound
    `MSE_ASSERT_IMPL(a_smooth_floor, i_clk, i_rst_n, o_strobe && o_res.smooth_count[SMOOTH_W-1], o_res.smooth_count >= -29'sd65536, "smooth count below floor")

endmodule

bind mandelbrot_smooth_escape_count mse_checker u_mse_checker (.*);

`default_nettype wire

// ===== tb/mandelbrot_smooth_escape_count_tb.sv =====
// Self-checking testbench for the smoothed Mandelbrot escape count block
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_smooth_escape_count_tb;
    import mse_pkg::*;

    localparam int FRAC        = 28;
    localparam int WATCH_LIMIT = 300000;
    localparam int SETTLE      = 200;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_req                  i_req = '0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_strobe;
    t_res                  o_res;

    // Mirror of the configuration registers
    logic [CNT_W-1:0] iter_limit = MAX_ITER_RST;
    logic [RAD_W-1:0] radius     = BAILOUT_RST;

    t_res pending_pixels[$];
    int   fail_count = 0;
    int   idle_cycles = 0;
    int   idle_pct = 0;

    mandelbrot_smooth_escape_count dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_res       (o_res)
    );

    always #10 i_clk = ~i_clk;

    // Signed product shifted right, truncated toward zero
    function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b, int s);
        logic [63:0]  ma, mb, r;
        logic [127:0] p;
        ma = a[63] ? (64'd0 - a) : a;
        mb = b[63] ? (64'd0 - b) : b;
        p  = {64'd0, ma} * {64'd0, mb};
        r  = 64'(p >> s);
        return (a[63] ^ b[63]) ? (64'd0 - r) : r;
    endfunction

    // log2 of an integer in Q.16 by repeated squaring
    function automatic logic [63:0] log2_fix(logic [63:0] v);
        int          e;
        logic [63:0] x, frac;
        if (v == 0) return 64'd0;
        e = 63;
        while (!v[e]) e--;
        x = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
        frac = 0;
        for (int i = 0; i < 16; i++) begin
            x = (x * x) >> 30;
            frac = frac << 1;
            if (x >= (64'd1 << 31)) begin
                x = x >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(e) << 16) | frac;
    endfunction

    // Iterate the orbit of one pixel and smooth its escape count
    function automatic t_res predict_pixel(t_req req);
        t_res        res;
        logic [63:0] cr, ci, x, y, xx, yy, xy, len2, thr, rr, lim;
        longint      n, smooth, a, b, c;
        logic        esc;
        cr = {{32{req.c_real[31]}}, req.c_real};
        ci = {{32{req.c_imag[31]}}, req.c_imag};
        rr = radius;
        if (rr < 2) rr = 2;
        if (rr > 256) rr = 256;
        lim = iter_limit;
        thr = (rr * rr) << LEN2_FRAC;
        x = 0; y = 0; len2 = 0; n = 0; esc = 1'b0;
        for (longint k = 0; k < lim; k++) begin
            xx = fx_mul(x, x, FRAC);
            yy = fx_mul(y, y, FRAC);
            xy = fx_mul(x, y, FRAC - 1);
            x = xx - yy + cr;
            y = xy + ci;
            len2 = fx_mul(x, x, 2 * FRAC - LEN2_FRAC) + fx_mul(y, y, 2 * FRAC - LEN2_FRAC);
            if (len2 > thr) begin
                esc = 1'b1;
                break;
            end
            n++;
        end
        smooth = n * 65536;
        if (esc) begin
            a = longint'(log2_fix(len2)) - (longint'(LEN2_FRAC) << 16);
            b = longint'(log2_fix(64'(a))) - (longint'(16) << 16);
            c = longint'(log2_fix(log2_fix(rr))) - (longint'(16) << 16);
            smooth -= b - c - 65536;
        end
        if (smooth < -65536) smooth = -65536;
        if (smooth > (longint'(1) << 28) - 1) smooth = (longint'(1) << 28) - 1;
        res.smooth_count = SMOOTH_W'(smooth);
        res.raw_count    = CNT_W'(n);
        res.escaped      = esc;
        return res;
    endfunction

    // Send one request; hold start high unless the sender idles next
    task automatic send_pixel(logic [31:0] re, logic [31:0] im);
        t_req req;
        req.c_real = re;
        req.c_imag = im;
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
        pending_pixels.push_back(predict_pixel(req));
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
            @(posedge i_clk);
        end
    endtask

    // Wait until every expected result is in, then let the pipe settle
    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_MAX_ITER) iter_limit = data;
        else if (idx == REG_BAILOUT) radius = data[RAD_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic send_corners;
        send_pixel(32'h0000_0000, 32'h0000_0000);
        send_pixel(32'h8000_0000, 32'h8000_0000);
        send_pixel(32'h7fff_ffff, 32'h7fff_ffff);
        send_pixel(32'h8000_0000, 32'h7fff_ffff);
        send_pixel(32'hE000_0000, 32'h0000_0000);
        send_pixel(32'h0400_0000, 32'h0000_0000);
        send_pixel(32'hFFFF_FFFF, 32'h0000_0001);
    endtask

    // Reset defaults and extreme coordinates
    task automatic test_defaults;
        idle_pct = 0;
        send_corners();
        drain();
    endtask

    // Limit at zero, one and widest; the widest runs one long inside orbit
    task automatic test_limits;
        cfg_write(REG_MAX_ITER, 12'd0);
        send_corners();
        drain();
        cfg_write(REG_MAX_ITER, 12'd1);
        send_corners();
        drain();
        cfg_write(REG_MAX_ITER, 12'd4095);
        send_pixel(32'h0000_0000, 32'h0000_0000);
        send_pixel(32'h7fff_ffff, 32'h8000_0000);
        drain();
    endtask

    // Radius below, at and above its range, plus a write to an unknown index
    task automatic test_radius;
        cfg_write(REG_MAX_ITER, 12'd20);
        cfg_write(REG_BAILOUT, 12'd0);
        send_pixel(32'h1000_0000, 32'h1000_0000);
        send_pixel(32'hF000_0000, 32'h0800_0000);
        drain();
        cfg_write(REG_BAILOUT, 12'd511);
        send_pixel(32'h1000_0000, 32'h1000_0000);
        send_pixel(32'h8000_0000, 32'h0000_0000);
        drain();
        cfg_write(REG_BAILOUT, 12'd256);
        cfg_write(8'd7, 12'hfff);
        send_pixel(32'h0800_0000, 32'h0C00_0000);
        drain();
    endtask

    function automatic logic [31:0] rand_coord;
        if ($urandom_range(99) < 70)
            return 32'($urandom_range(1181116006)) - 32'd590558003;
        return $urandom;
    endfunction

    // Random pixels over several configurations and idling mixes
    task automatic test_random;
        int pcts[4] = '{0, 84, 6, 0};
        for (int ph = 0; ph < 4; ph++) begin
            cfg_write(REG_MAX_ITER, CFG_DATA_W'($urandom_range(1, 24)));
            case (ph)
                0: cfg_write(REG_BAILOUT, 12'd2);
                1: cfg_write(REG_BAILOUT, 12'd256);
                default: cfg_write(REG_BAILOUT, CFG_DATA_W'($urandom_range(0, 4095)));
            endcase
            idle_pct = pcts[ph];
            for (int i = 0; i < 350; i++) send_pixel(rand_coord(), rand_coord());
            drain();
        end
    endtask

    // Compare each strobed result with the oldest prediction
    always @(posedge i_clk) begin
        t_res exp_res;
        if (i_rst_n && o_strobe) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_res);
                fail_count++;
            end else begin
                exp_res = pending_pixels.pop_front();
                if (o_res.smooth_count !== exp_res.smooth_count) begin
                    $display("%0t: smooth_count expected %h actual %h", $time,
                             exp_res.smooth_count, o_res.smooth_count);
                    fail_count++;
                end
                if (o_res.raw_count !== exp_res.raw_count) begin
                    $display("%0t: raw_count expected %h actual %h", $time,
                             exp_res.raw_count, o_res.raw_count);
                    fail_count++;
                end
                if (o_res.escaped !== exp_res.escaped) begin
                    $display("%0t: escaped expected %b actual %b", $time,
                             exp_res.escaped, o_res.escaped);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_limits();
        test_radius();
        test_random();
        if (fail_count == 0 && pending_pixels.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/mse_pkg.sv
hw/rtl/mse_front.sv
hw/rtl/mse_log2.sv
hw/rtl/mse_back.sv
hw/rtl/mandelbrot_smooth_escape_count.sv
hw/rtl/mse_checker.sv
tb/mandelbrot_smooth_escape_count_tb.sv
